/* design/gcd_pkg.sv */
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared widths, limits and angle tables for the great-circle distance unit.
// ----------------------------------------------------------------------------
package gcd_pkg;

  localparam int LAT_W    = 24;
  localparam int LON_W    = 25;
  localparam int DIST_W   = 23;
  localparam int RADIUS_W = 13;

  localparam int CORDIC_ITERATIONS_DEF = 24;
  localparam int ANGLE_FRAC_BITS_DEF   = 16;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 13'd6378;

  localparam logic signed [25:0] DEG90_Q16  = 26'sd5898240;
  localparam logic signed [25:0] DEG180_Q16 = 26'sd11796480;
  localparam logic signed [25:0] DEG360_Q16 = 26'sd23592960;

  localparam logic [26:0]         DEG2RAD_Q32 = 27'd74961321;
  localparam logic [DIST_W-1:0]   DIST_MAX    = 23'd6600000;
  localparam longint unsigned     GAIN_Q32    = 64'd2608131496;
  localparam longint unsigned     PI_Q32      = 64'd13493037704;

  localparam longint unsigned ATAN_Q32 [32] = '{
    64'd3373259426, 64'd1991351318, 64'd1052175346, 64'd534100635, 64'd268086748,
    64'd134174063, 64'd67103403, 64'd33553749, 64'd16777131, 64'd8388597,
    64'd4194303, 64'd2097152, 64'd1048576, 64'd524288, 64'd262144, 64'd131072,
    64'd65536, 64'd32768, 64'd16384, 64'd8192, 64'd4096, 64'd2048, 64'd1024,
    64'd512, 64'd256, 64'd128, 64'd64, 64'd32, 64'd16, 64'd8, 64'd4, 64'd2
  };

  // Rounds a Q32 constant to the given number of fractional bits.
  function automatic longint unsigned q32_to_qf(input longint unsigned t, input int f);
    return (t + (64'd1 << (31 - f))) >> (32 - f);
  endfunction

  function automatic longint unsigned atan_qf(input int i, input int f);
    return q32_to_qf(ATAN_Q32[i % 32], f);
  endfunction

endpackage

/* design/gcd_if.sv */
// ----------------------------------------------------------------------------
// gcd_in_if / gcd_out_if
// Valid/ready channels for point pairs and distance results.
// ----------------------------------------------------------------------------
interface gcd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [gcd_pkg::LAT_W-1:0]    first_lat;
  logic signed [gcd_pkg::LON_W-1:0]    first_lon;
  logic signed [gcd_pkg::LAT_W-1:0]    second_lat;
  logic signed [gcd_pkg::LON_W-1:0]    second_lon;

  modport source (output valid, first_lat, first_lon, second_lat, second_lon,
                  input ready);
  modport sink   (input valid, first_lat, first_lon, second_lat, second_lon,
                  output ready);
endinterface

interface gcd_out_if;
  logic                         valid;
  logic                         ready;
  logic [gcd_pkg::DIST_W-1:0]   distance_km;
  logic                         first_replaced;
  logic                         second_replaced;

  modport source (output valid, distance_km, first_replaced, second_replaced,
                  input ready);
  modport sink   (input valid, distance_km, first_replaced, second_replaced,
                  output ready);
endinterface

/* design/great_circle_distance_unit.sv */
// ----------------------------------------------------------------------------
// great_circle_distance_unit
// Spherical law of cosines distance with pipelined CORDIC and square root.
// ----------------------------------------------------------------------------
// Pipeline depth is set by the rotation CORDIC, the bitwise square root and
// the vectoring CORDIC, one stage per step. Throughput is one word per cycle;
// the whole pipeline holds only while the output word waits. Reset clears all
// valid bits and loads the radius register with 6378 km.
module great_circle_distance_unit #(
  parameter int CORDIC_ITERATIONS = gcd_pkg::CORDIC_ITERATIONS_DEF,
  parameter int ANGLE_FRAC_BITS   = gcd_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gcd_pkg::RADIUS_W-1:0]   cfg_wdata,
  gcd_in_if.sink                         req,
  gcd_out_if.source                      rsp
);

  localparam int F   = ANGLE_FRAC_BITS;
  localparam int W   = F + 3;
  localparam int NIT = CORDIC_ITERATIONS;
  localparam int SQ  = F + 1;
  localparam int NST = 17 + 2 * NIT + SQ;
  localparam int PW  = 51;
  localparam int RW  = gcd_pkg::RADIUS_W + F + 2;
  localparam int DS  = F - 8;

  localparam logic signed [W-1:0] ONE     = W'(64'd1 << F);
  localparam logic signed [W-1:0] GAIN_QF = W'(gcd_pkg::q32_to_qf(gcd_pkg::GAIN_Q32, F));
  localparam logic signed [W-1:0] PI_QF   = W'(gcd_pkg::q32_to_qf(gcd_pkg::PI_Q32, F));
  localparam logic [PW-1:0]       RAD_HALF = PW'(64'd1 << (47 - F));
  localparam logic [RW-1:0]       DIST_HALF = (DS > 0) ? RW'(64'd1 << (DS - 1)) : '0;

  function automatic logic signed [W-1:0] rnd(input logic signed [2*W-1:0] p);
    logic [2*W-1:0] mag;
    mag = p[2*W-1] ? (2*W)'(-p) : (2*W)'(p);
    mag = (mag + ((2*W)'(1) << (F - 1))) >> F;
    return p[2*W-1] ? -W'(mag) : W'(mag);
  endfunction

  logic                          ce;
  logic [gcd_pkg::RADIUS_W-1:0]  sphere_radius_km;
  logic                          vld [NST];
  logic [1:0]                    fl  [NST];

  assign ce        = !vld[NST-1] || rsp.ready;
  assign req.ready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius_km <= gcd_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      sphere_radius_km <= cfg_wdata;
    end
  end

  // Valid bits and replaced flags ride alongside every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ce) begin
      vld[0] <= req.valid;
    end
  end

  for (genvar k = 1; k < NST; k++) begin : g_vld
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (ce) begin
        vld[k] <= vld[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        fl[k] <= fl[k-1];
      end
    end
  end

  // Stage A: range check and replacement.
  logic bad1, bad2;
  logic signed [gcd_pkg::LAT_W-1:0] a_lat1, a_lat2;
  logic signed [gcd_pkg::LON_W-1:0] a_lon1, a_lon2;

  assign bad1 = 26'(req.first_lat) < -gcd_pkg::DEG90_Q16 ||
                26'(req.first_lat) > gcd_pkg::DEG90_Q16 ||
                26'(req.first_lon) < -gcd_pkg::DEG180_Q16 ||
                26'(req.first_lon) > gcd_pkg::DEG180_Q16;
  assign bad2 = 26'(req.second_lat) < -gcd_pkg::DEG90_Q16 ||
                26'(req.second_lat) > gcd_pkg::DEG90_Q16 ||
                26'(req.second_lon) < -gcd_pkg::DEG180_Q16 ||
                26'(req.second_lon) > gcd_pkg::DEG180_Q16;

  always_ff @(posedge clk) begin
    if (ce) begin
      fl[0]  <= {bad2, bad1};
      a_lat1 <= bad1 ? '0 : req.first_lat;
      a_lon1 <= bad1 ? '0 : req.first_lon;
      a_lat2 <= bad2 ? '0 : req.second_lat;
      a_lon2 <= bad2 ? '0 : req.second_lon;
    end
  end

  // Stage B: latitude magnitudes and longitude difference.
  logic [22:0]       b_m1, b_m2;
  logic              b_n1, b_n2;
  logic signed [25:0] b_diff;

  always_ff @(posedge clk) begin
    if (ce) begin
      b_n1   <= a_lat1[gcd_pkg::LAT_W-1];
      b_n2   <= a_lat2[gcd_pkg::LAT_W-1];
      b_m1   <= a_lat1[gcd_pkg::LAT_W-1] ? 23'(-a_lat1) : 23'(a_lat1);
      b_m2   <= a_lat2[gcd_pkg::LAT_W-1] ? 23'(-a_lat2) : 23'(a_lat2);
      b_diff <= 26'(a_lon2) - 26'(a_lon1);
    end
  end

  // Stage C: fold the difference into [0, 180] degrees.
  logic signed [25:0] ad;
  logic [22:0]        c_m1, c_m2;
  logic               c_n1, c_n2;
  logic signed [25:0] c_d;

  assign ad = b_diff[25] ? -b_diff : b_diff;

  always_ff @(posedge clk) begin
    if (ce) begin
      c_m1 <= b_m1;
      c_m2 <= b_m2;
      c_n1 <= b_n1;
      c_n2 <= b_n2;
      c_d  <= (ad > gcd_pkg::DEG180_Q16) ? gcd_pkg::DEG360_Q16 - ad : ad;
    end
  end

  // Stage D: fold into [0, 90] degrees; beyond 90 the cosine changes sign.
  logic [22:0] d_m1, d_m2, d_d;
  logic        d_n1, d_n2, d_nd;

  always_ff @(posedge clk) begin
    if (ce) begin
      d_m1 <= c_m1;
      d_m2 <= c_m2;
      d_n1 <= c_n1;
      d_n2 <= c_n2;
      d_nd <= c_d > gcd_pkg::DEG90_Q16;
      d_d  <= (c_d > gcd_pkg::DEG90_Q16) ? 23'(gcd_pkg::DEG180_Q16 - c_d) : 23'(c_d);
    end
  end

  // Stage E: degree to radian products.
  logic [PW-1:0] e_p [3];
  logic [2:0]    e_n;

  always_ff @(posedge clk) begin
    if (ce) begin
      e_p[0] <= PW'(d_m1) * PW'(gcd_pkg::DEG2RAD_Q32);
      e_p[1] <= PW'(d_m2) * PW'(gcd_pkg::DEG2RAD_Q32);
      e_p[2] <= PW'(d_d)  * PW'(gcd_pkg::DEG2RAD_Q32);
      e_n    <= {d_nd, d_n2, d_n1};
    end
  end

  // Rotation CORDIC: three lanes (first latitude, second latitude, dlon).
  logic signed [W-1:0] rx [3][NIT+1];
  logic signed [W-1:0] ry [3][NIT+1];
  logic signed [W-1:0] rz [3][NIT+1];
  logic [2:0]          rn [NIT+1];

  always_ff @(posedge clk) begin
    if (ce) begin
      rn[0] <= e_n;
    end
  end

  for (genvar u = 0; u < 3; u++) begin : g_lane
    always_ff @(posedge clk) begin
      if (ce) begin
        rx[u][0] <= GAIN_QF;
        ry[u][0] <= '0;
        rz[u][0] <= W'((e_p[u] + RAD_HALF) >> (48 - F));
      end
    end
    for (genvar i = 0; i < NIT; i++) begin : g_rot
      localparam logic signed [W-1:0] ANG = W'(gcd_pkg::atan_qf(i, F));
      always_ff @(posedge clk) begin
        if (ce) begin
          if (!rz[u][i][W-1]) begin
            rx[u][i+1] <= rx[u][i] - (ry[u][i] >>> i);
            ry[u][i+1] <= ry[u][i] + (rx[u][i] >>> i);
            rz[u][i+1] <= rz[u][i] - ANG;
          end else begin
            rx[u][i+1] <= rx[u][i] + (ry[u][i] >>> i);
            ry[u][i+1] <= ry[u][i] - (rx[u][i] >>> i);
            rz[u][i+1] <= rz[u][i] + ANG;
          end
        end
      end
    end
  end

  for (genvar i = 0; i < NIT; i++) begin : g_rn
    always_ff @(posedge clk) begin
      if (ce) begin
        rn[i+1] <= rn[i];
      end
    end
  end

  // Stage G: restore signs.
  logic signed [W-1:0] g_sa, g_ca, g_sb, g_cb, g_cd;

  always_ff @(posedge clk) begin
    if (ce) begin
      g_ca <= rx[0][NIT];
      g_sa <= rn[NIT][0] ? -ry[0][NIT] : ry[0][NIT];
      g_cb <= rx[1][NIT];
      g_sb <= rn[NIT][1] ? -ry[1][NIT] : ry[1][NIT];
      g_cd <= rn[NIT][2] ? -rx[2][NIT] : rx[2][NIT];
    end
  end

  // Stages H to K: c = sa*sb + (ca*cb)*cd, clamped to [-1, 1].
  logic signed [2*W-1:0] h_pab, h_pcc, j_raw;
  logic signed [W-1:0]   h_cd, i_p1, i_p2, i_cd, j_p1, k_c;
  logic signed [W:0]     sum;

  always_ff @(posedge clk) begin
    if (ce) begin
      h_pab <= (2*W)'(g_sa) * (2*W)'(g_sb);
      h_pcc <= (2*W)'(g_ca) * (2*W)'(g_cb);
      h_cd  <= g_cd;
      i_p1  <= rnd(h_pab);
      i_p2  <= rnd(h_pcc);
      i_cd  <= h_cd;
      j_raw <= (2*W)'(i_p2) * (2*W)'(i_cd);
      j_p1  <= i_p1;
    end
  end

  assign sum = (W+1)'(j_p1) + (W+1)'(rnd(j_raw));

  always_ff @(posedge clk) begin
    if (ce) begin
      if (sum > (W+1)'(ONE)) begin
        k_c <= ONE;
      end else if (sum < -(W+1)'(ONE)) begin
        k_c <= -ONE;
      end else begin
        k_c <= W'(sum);
      end
    end
  end

  // Stages L to N: |c| and 1 - c^2.
  logic [F:0]       l_ac, m_ac;
  logic             l_cn, m_cn;
  logic [2*F+1:0]   m_sq;

  always_ff @(posedge clk) begin
    if (ce) begin
      l_cn <= k_c[W-1];
      l_ac <= k_c[W-1] ? (F+1)'(-k_c) : (F+1)'(k_c);
      m_sq <= (2*F+2)'(l_ac) * (2*F+2)'(l_ac);
      m_ac <= l_ac;
      m_cn <= l_cn;
    end
  end

  // Square root, one result bit per stage from the top.
  logic [2*F:0] sr_rem  [SQ+1];
  logic [F:0]   sr_root [SQ+1];
  logic [F:0]   sr_ac   [SQ+1];
  logic         sr_cn   [SQ+1];

  always_ff @(posedge clk) begin
    if (ce) begin
      sr_rem[0]  <= (2*F+1)'((2*F+2)'(1) << (2*F)) - (2*F+1)'(m_sq);
      sr_root[0] <= '0;
      sr_ac[0]   <= m_ac;
      sr_cn[0]   <= m_cn;
    end
  end

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam int B = F - j;
    logic [2*F+2:0] trial;
    assign trial = ((2*F+3)'(sr_root[j]) << (B + 1)) + ((2*F+3)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (ce) begin
        sr_ac[j+1] <= sr_ac[j];
        sr_cn[j+1] <= sr_cn[j];
        if ((2*F+3)'(sr_rem[j]) >= trial) begin
          sr_rem[j+1]  <= (2*F+1)'((2*F+3)'(sr_rem[j]) - trial);
          sr_root[j+1] <= sr_root[j] | ((F+1)'(1) << B);
        end else begin
          sr_rem[j+1]  <= sr_rem[j];
          sr_root[j+1] <= sr_root[j];
        end
      end
    end
  end

  // Vectoring CORDIC on (|c|, sqrt(1 - c^2)) gives acos(|c|).
  logic signed [W-1:0] vx [NIT+1];
  logic signed [W-1:0] vy [NIT+1];
  logic signed [W-1:0] vz [NIT+1];
  logic                vcn [NIT+1];

  assign vx[0]  = W'(sr_ac[SQ]);
  assign vy[0]  = W'(sr_root[SQ]);
  assign vz[0]  = '0;
  assign vcn[0] = sr_cn[SQ];

  for (genvar i = 0; i < NIT; i++) begin : g_vec
    localparam logic signed [W-1:0] ANG = W'(gcd_pkg::atan_qf(i, F));
    always_ff @(posedge clk) begin
      if (ce) begin
        vcn[i+1] <= vcn[i];
        if (!vy[i][W-1]) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + ANG;
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - ANG;
        end
      end
    end
  end

  // Stage O: central angle, mirrored for negative c and kept in [0, pi].
  logic signed [W-1:0] t0, t1;
  logic [F+1:0]        o_th;

  assign t0 = vz[NIT][W-1] ? '0 : vz[NIT];
  assign t1 = vcn[NIT] ? PI_QF - t0 : t0;

  always_ff @(posedge clk) begin
    if (ce) begin
      if (t1[W-1]) begin
        o_th <= '0;
      end else if (t1 > PI_QF) begin
        o_th <= (F+2)'(PI_QF);
      end else begin
        o_th <= (F+2)'(t1);
      end
    end
  end

  // Stages P and Q: scale by radius, round to km/256, saturate.
  logic [RW-1:0]              p_raw, p_rnd;
  logic [gcd_pkg::DIST_W-1:0] q_dist;

  always_ff @(posedge clk) begin
    if (ce) begin
      p_raw <= RW'(sphere_radius_km) * RW'(o_th);
    end
  end

  assign p_rnd = (p_raw + DIST_HALF) >> DS;

  always_ff @(posedge clk) begin
    if (ce) begin
      q_dist <= (p_rnd > RW'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX
                                                  : gcd_pkg::DIST_W'(p_rnd);
    end
  end

  assign rsp.valid           = vld[NST-1];
  assign rsp.distance_km     = q_dist;
  assign rsp.first_replaced  = fl[NST-1][0];
  assign rsp.second_replaced = fl[NST-1][1];

endmodule

/* bench/great_circle_distance_unit_tb.sv */
// ----------------------------------------------------------------------------
// great_circle_distance_unit_tb
// Drives point pairs through the distance unit under random back-pressure and
// checks every result word against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module great_circle_distance_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITER = gcd_pkg::CORDIC_ITERATIONS_DEF;
  localparam int FRAC = gcd_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 200;
  localparam int LAT90 = 5898240;
  localparam int LON180 = 11796480;

  typedef struct packed {
    logic [gcd_pkg::DIST_W-1:0] distance_km;
    logic              first_replaced;
    logic              second_replaced;
  } dist_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [gcd_pkg::RADIUS_W-1:0] cfg_wdata = '0;

  gcd_in_if  req ();
  gcd_out_if rsp ();

  great_circle_distance_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req.sink), .rsp(rsp.source)
  );

  always #5 clk = ~clk;

  dist_word_t expected_q[$];
  logic [gcd_pkg::RADIUS_W-1:0] radius_km = gcd_pkg::RADIUS_RESET;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  initial begin
    req.valid = 1'b0;
    req.first_lat = '0;
    req.first_lon = '0;
    req.second_lat = '0;
    req.second_lon = '0;
    rsp.ready = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic longint round_half_away(longint v, int s);
    longint m;
    if (s == 0) return v;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 << (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint to_frac(longint unsigned t);
    return round_half_away(longint'(t), 32 - FRAC);
  endfunction

  function automatic longint mul_frac(longint a, longint b);
    return round_half_away(a * b, FRAC);
  endfunction

  function automatic longint deg_to_rad(longint d);
    return round_half_away(d * longint'(gcd_pkg::DEG2RAD_Q32), 48 - FRAC);
  endfunction

  function automatic void rotate_angle(input longint z, output longint cosv,
                                       output longint sinv);
    longint x, y, dx, dy, a;
    x = to_frac(gcd_pkg::GAIN_Q32);
    y = 0;
    for (int i = 0; i < ITER; i++) begin
      a = to_frac(gcd_pkg::ATAN_Q32[i % 32]);
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= a;
      end else begin
        x += dx; y -= dy; z += a;
      end
    end
    cosv = x;
    sinv = y;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, dx, dy, a;
    z = 0;
    for (int i = 0; i < ITER; i++) begin
      a = to_frac(gcd_pkg::ATAN_Q32[i % 32]);
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += a;
      end else begin
        x -= dx; y += dy; z -= a;
      end
    end
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit off_globe(longint lat, longint lon);
    return lat < -LAT90 || lat > LAT90 || lon < -LON180 || lon > LON180;
  endfunction

  function automatic void lat_sin_cos(input longint lat, output longint c,
                                      output longint s);
    longint m;
    m = (lat < 0) ? -lat : lat;
    rotate_angle(deg_to_rad(m), c, s);
    if (lat < 0) s = -s;
  endfunction

  function automatic dist_word_t predict_distance(
      logic signed [gcd_pkg::LAT_W-1:0] lat_a, logic signed [gcd_pkg::LON_W-1:0] lon_a,
      logic signed [gcd_pkg::LAT_W-1:0] lat_b, logic signed [gcd_pkg::LON_W-1:0] lon_b);
    longint one, pi_q, la, oa, lb, ob, sa, ca, sb, cb, cd, unused_s;
    longint d, c, ac, theta, dist_val;
    bit neg;
    dist_word_t w;
    one = 64'sd1 << FRAC;
    pi_q = to_frac(gcd_pkg::PI_Q32);
    la = lat_a; oa = lon_a; lb = lat_b; ob = lon_b;
    w.first_replaced = off_globe(la, oa);
    w.second_replaced = off_globe(lb, ob);
    if (w.first_replaced) begin la = 0; oa = 0; end
    if (w.second_replaced) begin lb = 0; ob = 0; end
    lat_sin_cos(la, ca, sa);
    lat_sin_cos(lb, cb, sb);
    // Fold the longitude difference into [0, 90] degrees, tracking cos sign.
    neg = 1'b0;
    d = ob - oa;
    if (d < 0) d = -d;
    if (d > LON180) d = 2 * LON180 - d;
    if (d > LAT90) begin
      d = LON180 - d;
      neg = 1'b1;
    end
    rotate_angle(deg_to_rad(d), cd, unused_s);
    if (neg) cd = -cd;
    c = mul_frac(sa, sb) + mul_frac(mul_frac(ca, cb), cd);
    if (c > one) c = one;
    if (c < -one) c = -one;
    ac = (c < 0) ? -c : c;
    theta = vector_angle(ac, longint'(int_sqrt(longint'(one * one - ac * ac))));
    if (theta < 0) theta = 0;
    if (c < 0) theta = pi_q - theta;
    if (theta < 0) theta = 0;
    if (theta > pi_q) theta = pi_q;
    dist_val = round_half_away(longint'(radius_km) * theta, FRAC - 8);
    if (dist_val > longint'(gcd_pkg::DIST_MAX)) dist_val = longint'(gcd_pkg::DIST_MAX);
    if (dist_val < 0) dist_val = 0;
    w.distance_km = dist_val[gcd_pkg::DIST_W-1:0];
    return w;
  endfunction

  // ---------------- result side ----------------
  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    dist_word_t exp_w;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word dist=%0d f1=%0b f2=%0b", $time,
                 rsp.distance_km, rsp.first_replaced, rsp.second_replaced);
        fail_count++;
      end else begin
        exp_w = expected_q.pop_front();
        if (rsp.distance_km !== exp_w.distance_km) begin
          $display("%0t: distance_km expected %0d actual %0d", $time,
                   exp_w.distance_km, rsp.distance_km);
          fail_count++;
        end
        if (rsp.first_replaced !== exp_w.first_replaced) begin
          $display("%0t: first_replaced expected %0b actual %0b", $time,
                   exp_w.first_replaced, rsp.first_replaced);
          fail_count++;
        end
        if (rsp.second_replaced !== exp_w.second_replaced) begin
          $display("%0t: second_replaced expected %0b actual %0b", $time,
                   exp_w.second_replaced, rsp.second_replaced);
          fail_count++;
        end
      end
    end
  end

  // A run with no accepted word for too long is a hang.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------- stimulus helpers ----------------
  task automatic send_pair(int lat_a, int lon_a, int lat_b, int lon_b);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.first_lat <= lat_a[gcd_pkg::LAT_W-1:0];
    req.first_lon <= lon_a[gcd_pkg::LON_W-1:0];
    req.second_lat <= lat_b[gcd_pkg::LAT_W-1:0];
    req.second_lon <= lon_b[gcd_pkg::LON_W-1:0];
    expected_q.push_back(predict_distance(lat_a[gcd_pkg::LAT_W-1:0],
                                          lon_a[gcd_pkg::LON_W-1:0],
                                          lat_b[gcd_pkg::LAT_W-1:0],
                                          lon_b[gcd_pkg::LON_W-1:0]));
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_radius(logic [gcd_pkg::RADIUS_W-1:0] r);
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    radius_km = r;
    @(posedge clk);
  endtask

  function automatic int rand_lat();
    int k;
    k = $urandom_range(99);
    if (k < 85) return int'($urandom_range(2 * LAT90)) - LAT90;
    if (k < 92) return LAT90 + int'($urandom_range(2)) - 1;
    if (k < 95) return -LAT90 + int'($urandom_range(2)) - 1;
    return int'($urandom());
  endfunction

  function automatic int rand_lon();
    int k;
    k = $urandom_range(99);
    if (k < 85) return int'($urandom_range(2 * LON180)) - LON180;
    if (k < 92) return LON180 + int'($urandom_range(2)) - 1;
    if (k < 95) return -LON180 + int'($urandom_range(2)) - 1;
    return int'($urandom());
  endfunction

  task automatic random_pairs(int n);
    for (int i = 0; i < n; i++) begin
      send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
      // Now and then hold the sender until the pipeline has emptied.
      if ($urandom_range(199) == 0) begin
        req.valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
      end
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    send_pair(0, 0, 0, 0);
    send_pair(LAT90, 0, -LAT90, 0);
    send_pair(0, 0, 0, LON180);
    send_pair(0, -LON180, 0, LON180);
    send_pair(0, LON180, 0, -LON180 + 65536);
    send_pair(LAT90 + 1, 0, 0, 65536);
    send_pair(0, 0, -LAT90 - 1, 0);
    send_pair(0, LON180 + 1, 0, -LON180 - 1);
    send_pair(-8388608, -16777216, 8388607, 16777215);
    send_pair(8388607, 16777215, -8388608, -16777216);
    send_pair(2000000, 3000000, 2000000, 3000001);
    send_pair(3342336, -4849664, -3342336, 6946816);
    send_pair(-LAT90, LON180, LAT90, -LON180);
    send_pair(2621440, 0, -2621440, LON180);
    send_pair(0, 5898240, 0, -5898240);
    send_pair(-1, -1, 1, 1);
    drain();
  endtask

  task automatic test_radius_extremes();
    logic [gcd_pkg::RADIUS_W-1:0] radii [4] = '{13'd1, 13'd8191, 13'd0, 13'd6371};
    foreach (radii[i]) begin
      write_radius(radii[i]);
      send_pair(LAT90, 0, -LAT90, 0);
      send_pair(0, 0, 0, LON180);
      send_pair(100000, 200000, -300000, 400000);
      random_pairs(8);
      drain();
    end
  endtask

  task automatic test_random_traffic(int s_pct, int r_pct, int n);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    write_radius(13'($urandom_range(1, 8191)));
    random_pairs(n);
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 36;
    recv_idle_pct = 73;
    test_directed();
    test_radius_extremes();
    test_random_traffic(36, 73, 560);
    test_random_traffic(73, 36, 560);
    test_random_traffic(0, 0, 560);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
design/gcd_pkg.sv
design/gcd_if.sv
design/great_circle_distance_unit.sv
bench/great_circle_distance_unit_tb.sv
